@@ rtl/stok_pkg.sv @@
// Shared types, codes and character helpers for the source tokenizer.
// No dependencies; the step logic, result register, top level and checker import this package.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int STOK_POS_BITS = 16;
    localparam int KW_LEN        = 9;
    localparam int SFX_LEN       = 3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_IDENT  = 3'd1,
        M_MINUS  = 3'd2,
        M_NUMBER = 3'd3,
        M_SUFFIX = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        K_IDENT     = 4'd0,
        K_NUMBER    = 4'd1,
        K_LBRACKET  = 4'd2,
        K_RBRACKET  = 4'd3,
        K_LPAREN    = 4'd4,
        K_RPAREN    = 4'd5,
        K_LBRACE    = 4'd6,
        K_RBRACE    = 4'd7,
        K_LANGLE    = 4'd8,
        K_RANGLE    = 4'd9,
        K_COMMA     = 4'd10,
        K_NAMESPACE = 4'd11,
        K_END       = 4'd12
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        done;
        logic        last;
    } t_token;

    // Up to three tokens produced by one request, packed from slot 0.
    typedef struct packed {
        logic [1:0]   cnt;
        t_token [2:0] tok;
    } t_group;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return is_alpha(c) || c == CH_UNDER || c == CH_SLASH;
    endfunction

    function automatic logic is_id_body(input logic [7:0] c);
        return is_id_start(c) || is_digit(c);
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            8'h5B:   k = K_LBRACKET;
            8'h5D:   k = K_RBRACKET;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h3C:   k = K_LANGLE;
            8'h3E:   k = K_RANGLE;
            8'h2C:   k = K_COMMA;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // Characters of the keyword "namespace".
    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h6E;
            4'd1:    ch = 8'h61;
            4'd2:    ch = 8'h6D;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h73;
            4'd5:    ch = 8'h70;
            4'd6:    ch = 8'h61;
            4'd7:    ch = 8'h63;
            4'd8:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of the number suffix "i32".
    function automatic logic [7:0] sfx_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h69;
            4'd1:    ch = 8'h33;
            4'd2:    ch = 8'h32;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/stok_if.sv @@
// Request channel interfaces of the source tokenizer: source bytes in, tokens out.
// Depends on nothing; the payload widths are fixed by the token format.
`timescale 1ns / 1ps

interface stok_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_byte;

    modport source (output valid, output op, output char_byte, input ready);
    modport sink (input valid, input op, input char_byte, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        source_done;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output source_done, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input source_done, input last_of_run, output ready
    );
endinterface

@@ rtl/stok_step.sv @@
// Scanner state and the per-byte step logic that produces up to three tokens.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_step #(
    parameter int POS_BITS = stok_pkg::STOK_POS_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_op,
    input  logic [7:0]      i_byte,
    output stok_pkg::t_group o_group
);
    import stok_pkg::*;

    typedef logic [POS_BITS-1:0] t_pos;

    localparam t_pos POS_MAX = '1;
    localparam int   EW      = (POS_BITS > 16) ? POS_BITS : 16;

    t_mode       r_mode, n_mode;
    t_pos        r_pos, n_pos;
    t_pos        r_pstart, n_pstart;
    t_pos        r_plen, n_plen;
    logic [3:0]  r_kidx, n_kidx;
    logic        r_kmatch, n_kmatch;

    logic        c_v [3];
    t_token      c_tok [3];

    logic        go_fresh, id_run;
    t_pos        id_start, id_len;
    logic [3:0]  id_kidx;
    logic        id_kmatch;

    logic        f_space, f_ids, f_dig, f_minus, f_emit;
    t_kind       f_kind;
    t_mode       f_mode;

    logic [1:0]  cnt;
    t_group      grp;

    function automatic logic [15:0] clip16(input t_pos v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > EW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic t_pos inc_sat(input t_pos v);
        return (v == POS_MAX) ? v : v + t_pos'(1);
    endfunction

    function automatic t_pos add3_sat(input t_pos v);
        logic [POS_BITS:0] s;
        s = {1'b0, v} + (POS_BITS + 1)'(3);
        return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
    endfunction

    // Start of a partial suffix that is re-read as an identifier.
    function automatic t_pos back_off(input t_pos p, input logic [3:0] k);
        return (p >= t_pos'(k)) ? p - t_pos'(k) : '0;
    endfunction

    function automatic t_token mk(input t_kind k, input t_pos s, input t_pos l,
                                  input logic d);
        t_token t;
        t.kind   = k;
        t.start  = clip16(s);
        t.length = clip16(l);
        t.done   = d;
        t.last   = 1'b0;
        return t;
    endfunction

    // Classification of the byte as the first character of a new token.
    always_comb begin
        f_space = is_space(i_byte);
        f_ids   = is_id_start(i_byte);
        f_dig   = is_digit(i_byte);
        f_minus = (i_byte == CH_MINUS);
        f_kind  = punct_kind(i_byte);
        f_emit  = !f_space && !f_ids && !f_dig && !f_minus;
        if (f_ids) begin
            f_mode = M_IDENT;
        end else if (f_dig) begin
            f_mode = M_NUMBER;
        end else if (f_minus) begin
            f_mode = M_MINUS;
        end else begin
            f_mode = M_IDLE;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_pstart  = r_pstart;
        n_plen    = r_plen;
        n_kidx    = r_kidx;
        n_kmatch  = r_kmatch;
        go_fresh  = 1'b0;
        id_run    = 1'b0;
        id_start  = r_pstart;
        id_len    = r_plen;
        id_kidx   = r_kidx;
        id_kmatch = r_kmatch;
        for (int k = 0; k < 3; k++) begin
            c_v[k]   = 1'b0;
            c_tok[k] = '0;
        end

        if (!i_op) begin
            n_pos = inc_sat(r_pos);
            unique case (r_mode)
                M_IDLE: begin
                    go_fresh = 1'b1;
                end
                M_IDENT: begin
                    id_run = 1'b1;
                end
                M_MINUS: begin
                    if (f_dig) begin
                        n_mode = M_NUMBER;
                        n_plen = inc_sat(r_plen);
                    end else begin
                        c_v[0]   = 1'b1;
                        c_tok[0] = mk(K_END, r_pstart, '0, 1'b0);
                        go_fresh = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (f_dig) begin
                        n_plen = inc_sat(r_plen);
                    end else if (i_byte == sfx_char(4'd0)) begin
                        n_mode = M_SUFFIX;
                        n_kidx = 4'd1;
                    end else begin
                        c_v[0]   = 1'b1;
                        c_tok[0] = mk(K_NUMBER, r_pstart, r_plen, 1'b0);
                        go_fresh = 1'b1;
                    end
                end
                M_SUFFIX: begin
                    if (r_kidx < 4'(SFX_LEN) && i_byte == sfx_char(r_kidx)) begin
                        n_kidx = r_kidx + 4'd1;
                        if (r_kidx + 4'd1 == 4'(SFX_LEN)) begin
                            c_v[0]   = 1'b1;
                            c_tok[0] = mk(K_NUMBER, r_pstart, add3_sat(r_plen), 1'b0);
                            n_mode   = M_IDLE;
                            n_kidx   = '0;
                        end
                    end else begin
                        // The number ends; the partial suffix starts an identifier.
                        c_v[0]    = 1'b1;
                        c_tok[0]  = mk(K_NUMBER, r_pstart, r_plen, 1'b0);
                        id_start  = back_off(r_pos, r_kidx);
                        id_len    = t_pos'(r_kidx);
                        id_kidx   = r_kidx;
                        id_kmatch = 1'b0;
                        n_pstart  = id_start;
                        n_plen    = id_len;
                        n_kmatch  = 1'b0;
                        n_mode    = M_IDENT;
                        id_run    = 1'b1;
                    end
                end
                default: begin
                    go_fresh = 1'b1;
                end
            endcase

            if (id_run) begin
                if (is_id_body(i_byte)) begin
                    n_plen = inc_sat(id_len);
                    if (id_kmatch && id_kidx < 4'(KW_LEN) && i_byte == kw_char(id_kidx)) begin
                        n_kidx = id_kidx + 4'd1;
                    end else begin
                        n_kmatch = 1'b0;
                    end
                end else begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = mk((id_kmatch && id_kidx == 4'(KW_LEN)) ? K_NAMESPACE : K_IDENT,
                                  id_start, id_len, 1'b0);
                    go_fresh = 1'b1;
                end
            end

            if (go_fresh) begin
                n_mode = f_mode;
                if (!f_space) begin
                    n_pstart = f_emit ? '0 : r_pos;
                    n_plen   = f_emit ? '0 : t_pos'(1);
                    n_kmatch = f_ids && (i_byte == kw_char(4'd0));
                    n_kidx   = (f_ids && i_byte == kw_char(4'd0)) ? 4'd1 : 4'd0;
                end
                c_v[2]   = f_emit;
                c_tok[2] = mk(f_kind, r_pos, (f_kind == K_END) ? '0 : t_pos'(1), 1'b0);
            end
        end else begin
            // End of source: flush the pending token or tokens, then the final End token.
            unique case (r_mode)
                M_IDENT: begin
                    c_v[0]   = 1'b1;
                    c_tok[0] = mk((r_kmatch && r_kidx == 4'(KW_LEN)) ? K_NAMESPACE : K_IDENT,
                                  r_pstart, r_plen, 1'b0);
                end
                M_MINUS: begin
                    c_v[0]   = 1'b1;
                    c_tok[0] = mk(K_END, r_pstart, '0, 1'b0);
                end
                M_NUMBER: begin
                    c_v[0]   = 1'b1;
                    c_tok[0] = mk(K_NUMBER, r_pstart, r_plen, 1'b0);
                end
                M_SUFFIX: begin
                    c_v[0]   = 1'b1;
                    c_tok[0] = mk(K_NUMBER, r_pstart, r_plen, 1'b0);
                    c_v[1]   = 1'b1;
                    c_tok[1] = mk(K_IDENT, back_off(r_pos, r_kidx), t_pos'(r_kidx), 1'b0);
                end
                default: begin
                end
            endcase
            c_v[2]   = 1'b1;
            c_tok[2] = mk(K_END, r_pos, '0, 1'b1);
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_pstart = '0;
            n_plen   = '0;
            n_kidx   = '0;
            n_kmatch = 1'b0;
        end
    end

    // Pack the valid tokens in order and flag the last one.
    always_comb begin
        cnt = '0;
        grp = '0;
        for (int k = 0; k < 3; k++) begin
            if (c_v[k]) begin
                grp.tok[cnt] = c_tok[k];
                cnt = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0) begin
            grp.tok[cnt - 2'd1].last = 1'b1;
        end
        grp.cnt = cnt;
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_kidx   <= '0;
            r_kmatch <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_kidx   <= n_kidx;
            r_kmatch <= n_kmatch;
        end
    end

endmodule

@@ rtl/stok_outbuf.sv @@
// Result register that holds one request's tokens and hands them out one a cycle while ready is high.
// Depends on stok_pkg and stok_out_if.
`timescale 1ns / 1ps

module stok_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stok_pkg::t_group i_group,
    output logic             o_can_take,
    stok_out_if.source       o_token
);
    import stok_pkg::*;

    t_token [2:0] r_tok;
    logic [1:0]   r_left;
    logic         pop;
    logic         load;

    assign pop        = o_token.valid && o_token.ready;
    assign o_can_take = (r_left == 2'd0) || (r_left == 2'd1 && pop);
    assign load       = i_push && (i_group.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_group.cnt;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= i_group.tok;
        end else if (pop) begin
            r_tok[0] <= r_tok[1];
            r_tok[1] <= r_tok[2];
        end
    end

    assign o_token.valid        = (r_left != 2'd0);
    assign o_token.token_kind   = r_tok[0].kind;
    assign o_token.token_start  = r_tok[0].start;
    assign o_token.token_length = r_tok[0].length;
    assign o_token.source_done  = r_tok[0].done;
    assign o_token.last_of_run  = r_tok[0].last;

endmodule

@@ rtl/source_tokenizer.sv @@
// Top level of the source tokenizer: input register, step logic and token result register.
// Depends on stok_pkg, stok_if, stok_step and stok_outbuf.
//
// Usage:
//   i_byte carries one request per source byte (op = 0, char_byte) or an
//   end-of-source request (op = 1). o_token carries tokens as kind, start
//   offset, length, source_done and last_of_run; a request causes zero to
//   three tokens, and last_of_run marks the final one of each request.
//   A request passes through the input register, and its tokens through the
//   token register, before they reach o_token. Requests that cause no token
//   (whitespace, bytes that extend a token) retire one per cycle.
//   Throughput: one request per cycle while the token register is free; the
//   token port delivers one token per cycle while o_token.ready is high, and
//   a request that makes tokens waits until the token register can take them.
//   Reset: synchronous, active low; the scanner returns to idle at offset 0
//   and any held request or token is dropped. After end of source the
//   scanner also returns to offset 0.
//   Stall: while o_token.ready is low the token register holds; requests
//   that make no token keep retiring, and the first one that makes tokens
//   waits in the input register and blocks further requests.
`timescale 1ns / 1ps

module source_tokenizer #(
    parameter int POS_BITS = stok_pkg::STOK_POS_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stok_in_if.sink   i_byte,
    stok_out_if.source o_token
);
    import stok_pkg::*;

    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_byte;

    t_group     group;
    logic       can_take;
    logic       fire;
    logic       accept;

    // The step stage retires a request when it makes no token or the result
    // register can take its tokens.
    assign fire         = r_in_valid && ((group.cnt == 2'd0) || can_take);
    assign i_byte.ready = !r_in_valid || fire;
    assign accept       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_byte.op;
            r_byte <= i_byte.char_byte;
        end
    end

    stok_step #(
        .POS_BITS(POS_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .o_group (group)
    );

    stok_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (fire),
        .i_group    (group),
        .o_can_take (can_take),
        .o_token    (o_token)
    );

endmodule

@@ rtl/stok_checker.sv @@
// Port-level checks for the source tokenizer, attached to the top level by bind.
// Depends on stok_pkg and source_tokenizer.
`timescale 1ns / 1ps

module stok_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_kind,
    input logic [15:0] i_length,
    input logic        i_done,
    input logic        i_last
);
    import stok_pkg::*;

    // A held token does not change while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_length))
        else $error("token changed while stalled");

    // The final token of a source is an empty End token that closes its request.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> i_kind == K_END && i_length == 16'd0 && i_last)
        else $error("malformed end-of-source token");

    // Bracket, paren, brace, angle and comma tokens are one byte long.
    a_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind >= K_LBRACKET && i_kind <= K_COMMA |-> i_length == 16'd1)
        else $error("punctuation token with wrong length");

    // Back-pressure on the input only comes from tokens waiting at the output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no token pending");

    // Reset empties the token register.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("token valid right after reset");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_token.valid),
    .i_out_ready (o_token.ready),
    .i_kind      (o_token.token_kind),
    .i_length    (o_token.token_length),
    .i_done      (o_token.source_done),
    .i_last      (o_token.last_of_run)
);
